// ===== hw/rtl/voicing_frame_classifier_closing_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef VOICING_FRAME_CLASSIFIER_CLOSING_MACROS_SVH
`define VOICING_FRAME_CLASSIFIER_CLOSING_MACROS_SVH
`ifndef SYNTH
`define VFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VFC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define VFC_ASSERT(lbl, clk, rst, prop, msg)
`define VFC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/vfc_pkg.sv =====
package vfc_pkg;

  localparam int MAX_RUN_FRAMES = 32;
  localparam int HELD_DEPTH = MAX_RUN_FRAMES - 1;
  localparam int HELD_AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_RUN_FRAMES + 1);

  localparam int SCORE_W = 33;
  localparam int PROD_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int PROB_W = 18;
  localparam int CLAMP_W = 17;
  localparam int LEVEL_W = 18;
  localparam int CENT_W = 17;
  localparam int HF_W = 17;
  localparam int ZCR_W = 18;
  localparam int MINR_W = 6;
  localparam int CLASS_W = 2;
  localparam int CFG_W = 33;
  localparam int IDX_W = 3;
  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SILENCE  = 2'd0,
    CLS_VOICED   = 2'd1,
    CLS_SIBILANT = 2'd2
  } frame_class_t;

  typedef enum logic [IDX_W-1:0] {
    REG_UV_WEIGHT    = 3'd0,
    REG_VAD_WEIGHT   = 3'd1,
    REG_VOICED_THR   = 3'd2,
    REG_SILENCE_LVL  = 3'd3,
    REG_HF_RATIO_THR = 3'd4,
    REG_CENTROID_THR = 3'd5,
    REG_CROSSING_THR = 3'd6,
    REG_MIN_RUN      = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_FLUSH,
    ST_CUR,
    ST_STORE
  } seq_state_t;

  typedef struct packed {
    logic                       start;
    logic [WEIGHT_W-1:0]        uv_weight;
    logic [WEIGHT_W-1:0]        vad_weight;
    logic signed [PROB_W-1:0]   uv;
    logic signed [PROB_W-1:0]   vad;
  } score_req_t;

endpackage

// ===== hw/rtl/vfc_ram.sv =====
module vfc_ram #(
  parameter int DEPTH = 31,
  parameter int WIDTH = 33,
  parameter int AW = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/vfc_score.sv =====
module vfc_score (
  input  logic                       clk,
  input  logic                       rst,
  input  vfc_pkg::score_req_t        req,
  output logic                       done,
  output logic [vfc_pkg::SCORE_W-1:0] score
);

  import vfc_pkg::*;

  localparam logic [CLAMP_W-1:0] PROB_ONE = CLAMP_W'(65536);

  function automatic logic [CLAMP_W-1:0] clamp_prob(input logic signed [PROB_W-1:0] p);
    logic [CLAMP_W-1:0] r;
    if (p < 0) begin
      r = '0;
    end else if (p > $signed({1'b0, PROB_ONE})) begin
      r = PROB_ONE;
    end else begin
      r = p[CLAMP_W-1:0];
    end
    return r;
  endfunction

  logic [2:0]          step;
  logic [PROD_W-1:0]   prod;
  logic [SCORE_W-1:0]  acc;
  logic [WEIGHT_W-1:0] vad_w;
  logic [CLAMP_W-1:0]  vad_c;

  // One shared multiplier: first the unvoiced term, then the activity term.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= {step[1:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod  <= PROD_W'(req.uv_weight) * PROD_W'(PROB_ONE - clamp_prob(req.uv));
      vad_w <= req.vad_weight;
      vad_c <= clamp_prob(req.vad);
    end else if (step[0]) begin
      acc  <= SCORE_W'(prod);
      prod <= PROD_W'(vad_w) * PROD_W'(vad_c);
    end else if (step[1]) begin
      acc <= acc + SCORE_W'(prod);
    end
  end

  assign done  = step[2];
  assign score = acc;

endmodule

// ===== hw/rtl/voicing_frame_classifier_closing.sv =====
// Channel   Dir  Word fields (lowest bit first)
// s_*       in   s_tdata: unvoiced_prob, activity_prob, level_dbfs, centroid_hz,
//                hf_ratio, crossing_rate; s_tlast: final_frame
// m_*       out  m_tdata: frame_class, voicing_score; m_tlast: burst_end;
//                m_tuser: clip_end
// cfg_*     in   cfg_index selects a register, cfg_data is written when cfg_we is high
//
// One frame is taken at a time; the next is accepted once the previous one is done.
// A frame passes through accept, scoring in the shared score multiplier, the release of
// n held words (n <= 31) when a held run is flushed, the output of its own word when it
// goes out, and the held-score write-back step.
// The synchronous rst clears the run state; the held-score memory is not cleared.
// A low m_tready stalls the held-word reads until the result register drains.
`include "voicing_frame_classifier_closing_macros.svh"

module voicing_frame_classifier_closing (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // unvoiced_prob, activity_prob, level_dbfs, centroid_hz, hf_ratio, crossing_rate
  input  logic [vfc_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // frame_class, voicing_score
  output logic [vfc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  // clip_end
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [vfc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [vfc_pkg::CFG_W-1:0]         cfg_data
);

  import vfc_pkg::*;

  logic [WEIGHT_W-1:0]       uv_weight;
  logic [WEIGHT_W-1:0]       vad_weight;
  logic [SCORE_W-1:0]        voiced_threshold;
  logic signed [LEVEL_W-1:0] silence_level;
  logic [HF_W-1:0]           hf_ratio_threshold;
  logic [CENT_W-1:0]         centroid_threshold;
  logic [ZCR_W-1:0]          crossing_threshold;
  logic [MINR_W-1:0]         min_run_frames;

  logic signed [LEVEL_W-1:0] in_level;
  logic [CENT_W-1:0]         in_centroid;
  logic [HF_W-1:0]           in_hf;
  logic [ZCR_W-1:0]          in_crossing;
  logic                      in_final;

  frame_class_t              run_label;
  logic [CNT_W-1:0]          run_count;
  logic                      run_released;
  logic                      in_first_run;
  frame_class_t              last_emitted_label;

  frame_class_t              run_label_next;
  logic [CNT_W-1:0]          run_count_next;
  logic                      run_released_next;
  logic                      in_first_run_next;
  frame_class_t              last_emitted_label_next;

  seq_state_t                state;
  seq_state_t                state_next;

  score_req_t                score_req;
  logic                      score_done;
  logic [SCORE_W-1:0]        score;

  frame_class_t              cls;
  logic [CNT_W-1:0]          minr;
  logic                      decide;
  logic [CNT_W-1:0]          d_flush_n;
  frame_class_t              d_flush_label;
  logic                      d_emit;
  logic                      d_store;
  logic [HELD_AW-1:0]        d_store_addr;

  logic [CNT_W-1:0]          fl_count;
  frame_class_t              fl_label;
  logic                      cur_emit;
  frame_class_t              cur_label;
  logic [SCORE_W-1:0]        cur_score;
  logic                      is_final;
  logic                      store_en;
  logic [HELD_AW-1:0]        store_addr;
  logic [CNT_W-1:0]          k;
  logic                      rd_pend;

  logic                      ram_re;
  logic                      ram_we;
  logic [SCORE_W-1:0]        ram_rdata;

  logic                      out_free;
  logic                      adv;
  logic                      out_load_flush;
  logic                      out_load_cur;
  frame_class_t              out_class;
  logic [SCORE_W-1:0]        out_score;
  logic                      out_last;
  logic                      out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_weight          <= WEIGHT_W'(16384);
      vad_weight         <= '0;
      voiced_threshold   <= SCORE_W'(536870912);
      silence_level      <= LEVEL_W'(-12800);
      hf_ratio_threshold <= HF_W'(32768);
      centroid_threshold <= CENT_W'(4000);
      crossing_threshold <= ZCR_W'(3000);
      min_run_frames     <= MINR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_UV_WEIGHT:    uv_weight          <= cfg_data[WEIGHT_W-1:0];
        REG_VAD_WEIGHT:   vad_weight         <= cfg_data[WEIGHT_W-1:0];
        REG_VOICED_THR:   voiced_threshold   <= cfg_data[SCORE_W-1:0];
        REG_SILENCE_LVL:  silence_level      <= cfg_data[LEVEL_W-1:0];
        REG_HF_RATIO_THR: hf_ratio_threshold <= cfg_data[HF_W-1:0];
        REG_CENTROID_THR: centroid_threshold <= cfg_data[CENT_W-1:0];
        REG_CROSSING_THR: crossing_threshold <= cfg_data[ZCR_W-1:0];
        REG_MIN_RUN:      min_run_frames     <= cfg_data[MINR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level    <= s_tdata[53:36];
      in_centroid <= s_tdata[70:54];
      in_hf       <= s_tdata[87:71];
      in_crossing <= s_tdata[105:88];
      in_final    <= s_tlast;
    end
  end

  assign score_req.start      = s_tvalid && s_tready;
  assign score_req.uv_weight  = uv_weight;
  assign score_req.vad_weight = vad_weight;
  assign score_req.uv         = s_tdata[17:0];
  assign score_req.vad        = s_tdata[35:18];

  vfc_score u_score (
    .clk   (clk),
    .rst   (rst),
    .req   (score_req),
    .done  (score_done),
    .score (score)
  );

  always_comb begin
    if (score > voiced_threshold) begin
      cls = CLS_VOICED;
    end else if (in_level < silence_level) begin
      cls = CLS_SILENCE;
    end else if (in_hf > hf_ratio_threshold && in_centroid > centroid_threshold &&
                 in_crossing > crossing_threshold) begin
      cls = CLS_SIBILANT;
    end else begin
      cls = CLS_SILENCE;
    end
  end

  always_comb begin
    if (min_run_frames == '0) begin
      minr = CNT_W'(1);
    end else if (int'(min_run_frames) > MAX_RUN_FRAMES) begin
      minr = CNT_W'(MAX_RUN_FRAMES);
    end else begin
      minr = CNT_W'(min_run_frames);
    end
  end

  // Run decision for the frame whose score has just come out of the multiplier.
  always_comb begin
    logic do_open;
    logic open_first;
    logic open_rel;
    do_open                 = 1'b0;
    open_first              = in_first_run;
    open_rel                = 1'b0;
    d_flush_n               = '0;
    d_flush_label           = run_label;
    d_emit                  = 1'b0;
    d_store                 = 1'b0;
    d_store_addr            = '0;
    run_label_next          = run_label;
    run_count_next          = run_count;
    run_released_next       = run_released;
    in_first_run_next       = in_first_run;

    if (run_count == '0) begin
      do_open = 1'b1;
    end else if (cls == run_label) begin
      if (run_released) begin
        d_emit = 1'b1;
        if (run_count < minr) begin
          run_count_next = run_count + CNT_W'(1);
        end
      end else if (run_count >= minr - CNT_W'(1)) begin
        d_flush_n         = run_count;
        d_emit            = 1'b1;
        run_count_next    = minr;
        run_released_next = 1'b1;
      end else if (in_final) begin
        d_flush_n = run_count;
        d_emit    = 1'b1;
      end else begin
        if (run_count < CNT_W'(MAX_RUN_FRAMES - 1)) begin
          d_store      = 1'b1;
          d_store_addr = run_count[HELD_AW-1:0];
        end
        run_count_next = run_count + CNT_W'(1);
      end
    end else begin
      if (!run_released) begin
        d_flush_n     = run_count;
        d_flush_label = last_emitted_label;
      end
      open_first        = 1'b0;
      in_first_run_next = 1'b0;
      do_open           = 1'b1;
    end

    if (do_open) begin
      open_rel          = open_first || (minr <= CNT_W'(1));
      run_label_next    = cls;
      run_count_next    = CNT_W'(1);
      run_released_next = open_rel;
      if (open_rel || in_final) begin
        d_emit = 1'b1;
      end else begin
        d_store = 1'b1;
      end
    end

    if (in_final) begin
      last_emitted_label_next = CLS_SILENCE;
      run_label_next          = CLS_SILENCE;
      run_count_next          = '0;
      run_released_next       = 1'b0;
      in_first_run_next       = 1'b1;
    end else if (d_emit) begin
      last_emitted_label_next = cls;
    end else if (d_flush_n != '0) begin
      last_emitted_label_next = d_flush_label;
    end else begin
      last_emitted_label_next = last_emitted_label;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign adv      = !rd_pend || out_free;
  assign decide   = (state == ST_SCORE) && score_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    out_load_flush = 1'b0;
    out_load_cur   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (score_done) begin
          if (d_flush_n != '0) begin
            state_next = ST_FLUSH;
          end else if (d_emit) begin
            state_next = ST_CUR;
          end else begin
            state_next = ST_STORE;
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          out_load_flush = rd_pend;
          if (k != fl_count) begin
            ram_re = 1'b1;
          end else begin
            state_next = cur_emit ? ST_CUR : ST_STORE;
          end
        end
      end
      ST_CUR: begin
        if (out_free) begin
          out_load_cur = 1'b1;
          state_next   = ST_STORE;
        end
      end
      ST_STORE: begin
        ram_we     = store_en;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_label          <= CLS_SILENCE;
      run_count          <= '0;
      run_released       <= 1'b0;
      in_first_run       <= 1'b1;
      last_emitted_label <= CLS_SILENCE;
      rd_pend            <= 1'b0;
    end else if (decide) begin
      run_label          <= run_label_next;
      run_count          <= run_count_next;
      run_released       <= run_released_next;
      in_first_run       <= in_first_run_next;
      last_emitted_label <= last_emitted_label_next;
      rd_pend            <= 1'b0;
    end else if (state == ST_FLUSH && adv) begin
      rd_pend <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      fl_count   <= d_flush_n;
      fl_label   <= d_flush_label;
      cur_emit   <= d_emit;
      cur_label  <= cls;
      cur_score  <= score;
      is_final   <= in_final;
      store_en   <= d_store;
      store_addr <= d_store_addr;
      k          <= '0;
    end else if (ram_re) begin
      k <= k + CNT_W'(1);
    end
  end

  vfc_ram #(
    .DEPTH (HELD_DEPTH),
    .WIDTH (SCORE_W),
    .AW    (HELD_AW)
  ) u_held (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_addr),
    .wdata (cur_score),
    .re    (ram_re),
    .raddr (k[HELD_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load_flush || out_load_cur) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_flush) begin
      out_class <= fl_label;
      out_score <= ram_rdata;
      out_last  <= (k == fl_count) && !cur_emit;
      out_clip  <= (k == fl_count) && !cur_emit && is_final;
    end else if (out_load_cur) begin
      out_class <= cur_label;
      out_score <= cur_score;
      out_last  <= 1'b1;
      out_clip  <= is_final;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - CLASS_W - SCORE_W)'(0), out_score, out_class};
  assign m_tlast = out_last;
  assign m_tuser = out_clip;

  `VFC_ASSERT(a_load_into_free, clk, rst, (out_load_flush || out_load_cur) |-> out_free, "result register overwritten")
  `VFC_ASSERT(a_read_in_run, clk, rst, ram_re |-> (k < fl_count), "held read beyond the run")
  `VFC_NEVER(a_score_outside_wait, clk, rst, score_done && (state != ST_SCORE), "score finished outside wait")
  `VFC_ASSERT(a_held_run_bounded, clk, rst, !run_released |-> (run_count < CNT_W'(MAX_RUN_FRAMES)), "held run too long")

endmodule
